@@ sv/stit_pkg.sv @@
package stit_pkg;

	localparam int SCORE_BITS   = 32;
	localparam int FUNC_BITS    = 2;
	localparam int ENTRIES_DEF  = 8;
	localparam int TAG_BITS_DEF = 16;

	typedef enum logic [FUNC_BITS-1:0] {
		FN_INSERT = 2'd0,
		FN_CLEAR  = 2'd1,
		FN_READ   = 2'd2,
		FN_NOP    = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_WALK,
		ST_FIN
	} state_t;

endpackage

@@ sv/stit_ram.sv @@
module stit_ram #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 48,
	parameter int AW    = 3
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ sv/sorted_top_n_insert_table.sv @@
// Descending-sorted score table of up to ENTRIES entries (score plus tag).
// Input channel (in_valid/in_ready) carries one command per transaction:
// insert an entry, clear the table, read the entry at a rank, or no-op.
// Output channel (out_valid/out_ready) returns one result per command with
// the entry count after the command, insert status and position, and the
// read score and tag (zero where they do not apply).
// One command is worked at a time. An insert walks the table from the bottom
// up, moving one entry per cycle through the table memory (one read and one
// write port, registered read); a full table checks its last entry first.
// A result is first seen on the output the cycle after the command finishes.
// The output register holds one result; the next command is accepted while it
// waits, and that command only stalls at its own end if the receiver has not
// taken the previous result. Reset empties the table (count zero) and drops any
// pending result; the table memory itself is not cleared.
module sorted_top_n_insert_table
	import stit_pkg::*;
#(
	parameter int ENTRIES  = ENTRIES_DEF,
	parameter int TAG_BITS = TAG_BITS_DEF,
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	localparam int CNT_W   = $clog2(ENTRIES + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [FUNC_BITS-1:0]  func,
	input  logic [SCORE_BITS-1:0] new_score,
	input  logic [TAG_BITS-1:0]   new_tag,
	input  logic [IDX_W-1:0]      read_index,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [CNT_W-1:0]      entry_count,
	output logic                  inserted,
	output logic [IDX_W-1:0]      insert_position,
	output logic [SCORE_BITS-1:0] read_score,
	output logic [TAG_BITS-1:0]   read_tag
);

	localparam int ROW_W = SCORE_BITS + TAG_BITS;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(ENTRIES);

	state_t state_q, state_d;

	logic [CNT_W-1:0]      count_q;
	logic [IDX_W-1:0]      j_q;
	logic [SCORE_BITS-1:0] score_q;
	logic [TAG_BITS-1:0]   tag_q;

	logic                  res_ins_q;
	logic [IDX_W-1:0]      res_pos_q;
	logic [SCORE_BITS-1:0] res_score_q;
	logic [TAG_BITS-1:0]   res_tag_q;

	logic                  out_valid_q;
	logic [CNT_W-1:0]      out_count_q;
	logic                  out_ins_q;
	logic [IDX_W-1:0]      out_pos_q;
	logic [SCORE_BITS-1:0] out_score_q;
	logic [TAG_BITS-1:0]   out_tag_q;

	logic                  ram_wr_en;
	logic [IDX_W-1:0]      ram_wr_addr;
	logic [ROW_W-1:0]      ram_wr_data;
	logic                  ram_rd_en;
	logic [IDX_W-1:0]      ram_rd_addr;
	logic [ROW_W-1:0]      ram_rd_data;
	logic [SCORE_BITS-1:0] rd_score;
	logic [TAG_BITS-1:0]   rd_tag;

	logic accept;
	logic walk_stop;
	logic walk_shift;
	logic out_load;

	stit_ram #(
		.DEPTH (ENTRIES),
		.WIDTH (ROW_W),
		.AW    (IDX_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	assign rd_score = ram_rd_data[ROW_W-1:TAG_BITS];
	assign rd_tag   = ram_rd_data[TAG_BITS-1:0];
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		ram_rd_en   = 1'b0;
		ram_rd_addr = '0;
		ram_wr_en   = 1'b0;
		ram_wr_addr = j_q;
		ram_wr_data = ram_rd_data;
		walk_stop   = 1'b0;
		walk_shift  = 1'b0;
		out_load    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (func_t'(func))
						FN_INSERT: begin
							if (count_q == FULL) begin
								// full: check the last entry before anything moves
								ram_rd_en   = 1'b1;
								ram_rd_addr = LAST;
								state_d     = ST_CHECK;
							end else begin
								ram_rd_en   = (count_q != '0);
								ram_rd_addr = IDX_W'(count_q - 1'b1);
								state_d     = ST_WALK;
							end
						end
						FN_READ: begin
							if (CNT_W'(read_index) < count_q) begin
								ram_rd_en   = 1'b1;
								ram_rd_addr = read_index;
								state_d     = ST_READ;
							end else begin
								state_d = ST_FIN;
							end
						end
						default: state_d = ST_FIN;
					endcase
				end
			end
			ST_CHECK: begin
				if (score_q > rd_score) begin
					ram_rd_en   = (LAST != '0);
					ram_rd_addr = LAST - 1'b1;
					state_d     = ST_WALK;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_WALK: begin
				// stop once the entry above holds an equal or higher score
				walk_stop   = (j_q == '0) || (rd_score >= score_q);
				walk_shift  = !walk_stop;
				ram_wr_en   = 1'b1;
				ram_wr_addr = j_q;
				if (walk_stop) begin
					ram_wr_data = {score_q, tag_q};
					state_d     = ST_FIN;
				end else begin
					ram_rd_en   = (j_q != IDX_W'(1));
					ram_rd_addr = j_q - IDX_W'(2);
				end
			end
			ST_READ: state_d = ST_FIN;
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept && func_t'(func) == FN_CLEAR) begin
			count_q <= '0;
		end else if (walk_stop && count_q != FULL) begin
			count_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			score_q     <= new_score;
			tag_q       <= new_tag;
			j_q         <= (count_q == FULL) ? LAST : IDX_W'(count_q);
			res_ins_q   <= 1'b0;
			res_pos_q   <= '0;
			res_score_q <= '0;
			res_tag_q   <= '0;
		end else begin
			if (walk_shift) begin
				j_q <= j_q - 1'b1;
			end
			if (walk_stop) begin
				res_ins_q <= 1'b1;
				res_pos_q <= j_q;
			end
			if (state_q == ST_READ) begin
				res_score_q <= rd_score;
				res_tag_q   <= rd_tag;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_count_q <= count_q;
			out_ins_q   <= res_ins_q;
			out_pos_q   <= res_pos_q;
			out_score_q <= res_score_q;
			out_tag_q   <= res_tag_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign entry_count     = out_count_q;
	assign inserted        = out_ins_q;
	assign insert_position = out_pos_q;
	assign read_score      = out_score_q;
	assign read_tag        = out_tag_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("entry count above table size");

	a_check_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHECK |-> count_q == FULL)
		else $error("full-table check entered with room left");

	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> CNT_W'(j_q) <= count_q)
		else $error("insert walk outside the filled entries");

	a_pos_in_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && inserted |-> CNT_W'(insert_position) < entry_count)
		else $error("insert position not below entry count");

endmodule

@@ verif/score_table_checker.sv @@
`timescale 1ns / 1ps

module score_table_checker
	import stit_pkg::*;
#(
	parameter int ENTRIES  = ENTRIES_DEF,
	parameter int TAG_BITS = TAG_BITS_DEF,
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	localparam int CNT_W   = $clog2(ENTRIES + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [FUNC_BITS-1:0]  func,
	input  logic [SCORE_BITS-1:0] new_score,
	input  logic [TAG_BITS-1:0]   new_tag,
	input  logic [IDX_W-1:0]      read_index,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [CNT_W-1:0]      entry_count,
	input  logic                  inserted,
	input  logic [IDX_W-1:0]      insert_position,
	input  logic [SCORE_BITS-1:0] read_score,
	input  logic [TAG_BITS-1:0]   read_tag,
	output int                    mismatch_count,
	output int                    results_owed
);

	typedef struct packed {
		logic [CNT_W-1:0]      count;
		logic                  inserted;
		logic [IDX_W-1:0]      position;
		logic [SCORE_BITS-1:0] score;
		logic [TAG_BITS-1:0]   tag;
	} table_result_t;

	logic [SCORE_BITS-1:0] rank_score [ENTRIES];
	logic [TAG_BITS-1:0]   rank_tag   [ENTRIES];
	int                    rank_count;
	table_result_t         owed_results [$];

	// Update the shadow table with one command and return what the block must answer.
	function automatic table_result_t rank_table_apply(func_t op, logic [SCORE_BITS-1:0] score,
			logic [TAG_BITS-1:0] tag, logic [IDX_W-1:0] idx);
		table_result_t r;
		int            pos;
		int            last;
		r = '0;
		case (op)
			FN_INSERT: begin
				pos = 0;
				// equal scores stay above the newcomer
				while (pos < rank_count && score <= rank_score[pos])
					pos++;
				if (pos < ENTRIES) begin
					last = (rank_count < ENTRIES) ? rank_count : ENTRIES - 1;
					for (int j = last; j > pos; j--) begin
						rank_score[j] = rank_score[j-1];
						rank_tag[j]   = rank_tag[j-1];
					end
					rank_score[pos] = score;
					rank_tag[pos]   = tag;
					if (rank_count < ENTRIES)
						rank_count++;
					r.inserted = 1'b1;
					r.position = pos[IDX_W-1:0];
				end
			end
			FN_CLEAR: begin
				rank_count = 0;
			end
			FN_READ: begin
				if (idx < rank_count) begin
					r.score = rank_score[idx];
					r.tag   = rank_tag[idx];
				end
			end
			default: begin
			end
		endcase
		r.count = rank_count[CNT_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		mismatch_count++;
	endtask

	initial begin
		mismatch_count = 0;
		results_owed   = 0;
		rank_count     = 0;
		for (int j = 0; j < ENTRIES; j++) begin
			rank_score[j] = '0;
			rank_tag[j]   = '0;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		table_result_t want;
		if (!arst_n) begin
			owed_results.delete();
			rank_count   = 0;
			results_owed = 0;
		end else begin
			// a result never belongs to the command taken at the same edge, so check first
			if (out_valid && out_ready) begin
				if (owed_results.size() == 0) begin
					report_mismatch($sformatf("result with no command pending, count %0d",
						entry_count));
				end else begin
					want = owed_results.pop_front();
					if (entry_count !== want.count)
						report_mismatch($sformatf("entry_count got %0d want %0d",
							entry_count, want.count));
					if (inserted !== want.inserted)
						report_mismatch($sformatf("inserted got %0b want %0b",
							inserted, want.inserted));
					if (insert_position !== want.position)
						report_mismatch($sformatf("insert_position got %0d want %0d",
							insert_position, want.position));
					if (read_score !== want.score)
						report_mismatch($sformatf("read_score got %h want %h",
							read_score, want.score));
					if (read_tag !== want.tag)
						report_mismatch($sformatf("read_tag got %h want %h",
							read_tag, want.tag));
				end
			end
			if (in_valid && in_ready)
				owed_results.push_back(rank_table_apply(func_t'(func), new_score, new_tag,
					read_index));
			results_owed = owed_results.size();
		end
	end

endmodule

@@ verif/sorted_top_n_insert_table_tb.sv @@
`timescale 1ns / 1ps

module sorted_top_n_insert_table_tb;
	import stit_pkg::*;

	localparam int ENTRIES      = 8;
	localparam int TAG_BITS     = 16;
	localparam int IDX_W        = 3;
	localparam int CNT_W        = 4;
	localparam int RANDOM_ITEMS = 750;
	localparam int RUN_LIMIT    = 200000;
	localparam int DRAIN_CYCLES = 20;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  in_valid   = 1'b0;
	logic                  out_ready  = 1'b0;
	logic [FUNC_BITS-1:0]  func       = '0;
	logic [SCORE_BITS-1:0] new_score  = '0;
	logic [TAG_BITS-1:0]   new_tag    = '0;
	logic [IDX_W-1:0]      read_index = '0;
	logic                  quiet      = 1'b0;
	int                    cycles     = 0;

	logic                  in_ready;
	logic                  out_valid;
	logic [CNT_W-1:0]      entry_count;
	logic                  inserted;
	logic [IDX_W-1:0]      insert_position;
	logic [SCORE_BITS-1:0] read_score;
	logic [TAG_BITS-1:0]   read_tag;
	int                    mismatch_count;
	int                    results_owed;

	sorted_top_n_insert_table #(
		.ENTRIES  (ENTRIES),
		.TAG_BITS (TAG_BITS)
	) i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.func            (func),
		.new_score       (new_score),
		.new_tag         (new_tag),
		.read_index      (read_index),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.entry_count     (entry_count),
		.inserted        (inserted),
		.insert_position (insert_position),
		.read_score      (read_score),
		.read_tag        (read_tag)
	);

	score_table_checker #(
		.ENTRIES  (ENTRIES),
		.TAG_BITS (TAG_BITS)
	) i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.func            (func),
		.new_score       (new_score),
		.new_tag         (new_tag),
		.read_index      (read_index),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.entry_count     (entry_count),
		.inserted        (inserted),
		.insert_position (insert_position),
		.read_score      (read_score),
		.read_tag        (read_tag),
		.mismatch_count  (mismatch_count),
		.results_owed    (results_owed)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= RUN_LIMIT) begin
			$display("** sorted_top_n_insert_table: FAILED **");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_ready <= quiet || ($urandom_range(99) >= 23);
	end

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_cmd(func_t op, logic [SCORE_BITS-1:0] score, logic [TAG_BITS-1:0] tag,
			logic [IDX_W-1:0] idx);
		while (!quiet && $urandom_range(99) < 23) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		func       <= op;
		new_score  <= score;
		new_tag    <= tag;
		read_index <= idx;
		in_valid   <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Hold the sender until every result owed has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (results_owed != 0)
			@(negedge clk);
	endtask

	function automatic func_t pick_op();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return FN_INSERT;
		else if (r < 89)
			return FN_READ;
		else if (r < 93)
			return FN_CLEAR;
		return FN_NOP;
	endfunction

	// Favor a narrow range so ties and full-table rejects happen often.
	function automatic logic [SCORE_BITS-1:0] pick_score();
		case ($urandom_range(9))
			0, 1, 2, 3: return SCORE_BITS'($urandom_range(15));
			4:          return '0;
			5:          return '1;
			default:    return SCORE_BITS'($urandom);
		endcase
	endfunction

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_cmd(FN_READ, '1, '1, 3'd0);
		send_cmd(FN_NOP, 32'h5a5a_a5a5, 16'h3c3c, 3'd5);
		send_cmd(FN_INSERT, 32'd100, 16'd1, 3'd0);
		send_cmd(FN_INSERT, 32'd100, 16'd2, 3'd7);
		send_cmd(FN_INSERT, '1, '1, 3'd0);
		send_cmd(FN_INSERT, '0, '0, 3'd0);
		send_cmd(FN_INSERT, 32'd100, 16'd3, 3'd0);
		send_cmd(FN_INSERT, 32'd50, 16'd4, 3'd0);
		send_cmd(FN_INSERT, 32'd200, 16'd5, 3'd0);
		send_cmd(FN_INSERT, 32'd7, 16'd6, 3'd0);
		// table is full now: equal to the last entry is rejected, one above bumps it
		send_cmd(FN_INSERT, '0, 16'd9, 3'd0);
		send_cmd(FN_INSERT, 32'd1, 16'd10, 3'd0);
		send_cmd(FN_INSERT, '1, 16'h1234, 3'd0);
		for (int i = 0; i < ENTRIES; i++)
			send_cmd(FN_READ, '0, '0, IDX_W'(i));
		send_cmd(FN_CLEAR, '1, '1, 3'd7);
		send_cmd(FN_READ, '0, '0, 3'd7);
		send_cmd(FN_NOP, '1, '1, 3'd7);
		send_cmd(FN_INSERT, '0, '0, 3'd0);
		drain_results();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 150)
				drain_results();
			quiet <= (n >= 300 && n < 420);
			send_cmd(pick_op(), pick_score(), TAG_BITS'($urandom), IDX_W'($urandom_range(7)));
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("** sorted_top_n_insert_table: PASSED **");
		else
			$display("** sorted_top_n_insert_table: FAILED **");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/stit_pkg.sv
sv/stit_ram.sv
sv/sorted_top_n_insert_table.sv
verif/score_table_checker.sv
verif/sorted_top_n_insert_table_tb.sv
